FILE: rtl/ipfr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ipfr_pkg
// Types and constants shared by the fragment reassembly slot table.
// ----------------------------------------------------------------------------
package ipfr_pkg;

  localparam int unsigned NUM_SLOTS_DEF = 16;

  typedef enum logic [1:0] {
    StatMatch = 2'd0,
    StatFree  = 2'd1,
    StatEvict = 2'd2
  } slot_status_e;

  typedef struct packed {
    logic [15:0] frag_id;
    logic [12:0] frag_offset;
    logic        more_fragments;
    logic [15:0] payload_len;
    logic [31:0] now;
  } frag_t;

  typedef struct packed {
    logic [3:0]   slot;
    slot_status_e slot_status;
    logic [15:0]  byte_offset;
    logic         complete;
    logic [16:0]  total_len;
  } result_t;

  typedef struct packed {
    logic load;
    logic scan;
    logic commit;
  } ctrl_cmd_t;

endpackage

FILE: rtl/ipfr_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ipfr_ctrl
// Sequencer: idle, slot scan, commit; issues datapath commands.
// ----------------------------------------------------------------------------
module ipfr_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  logic                scan_done_i,
  output ipfr_pkg::ctrl_cmd_t cmd_o,
  output logic                busy_o,
  output logic                done_o
);
  import ipfr_pkg::*;

  typedef enum logic [1:0] {
    StIdle,
    StScan,
    StCommit
  } state_e;

  state_e state_q;
  logic   done_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      done_q  <= 1'b0;
    end else begin
      done_q <= 1'b0;
      case (state_q)
        StIdle: begin
          if (start_i) state_q <= StScan;
        end
        StScan: begin
          if (scan_done_i) state_q <= StCommit;
        end
        StCommit: begin
          state_q <= StIdle;
          done_q  <= 1'b1;
        end
        default: state_q <= StIdle;
      endcase
    end
  end

  always_comb begin
    cmd_o.load   = (state_q == StIdle) && start_i;
    cmd_o.scan   = (state_q == StScan);
    cmd_o.commit = (state_q == StCommit);
  end

  assign busy_o = (state_q != StIdle);
  assign done_o = done_q;

endmodule

FILE: rtl/ipfr_dpath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ipfr_dpath
// Slot tables, scan pointer, match/free/oldest trackers and result register.
// ----------------------------------------------------------------------------
module ipfr_dpath #(
  parameter int unsigned NUM_SLOTS = ipfr_pkg::NUM_SLOTS_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  ipfr_pkg::ctrl_cmd_t cmd_i,
  input  ipfr_pkg::frag_t     frag_i,
  output logic                scan_done_o,
  output ipfr_pkg::result_t   result_o
);
  import ipfr_pkg::*;

  localparam int unsigned IdxW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam int unsigned CntW = $clog2(NUM_SLOTS + 1);
  localparam logic [IdxW-1:0] LastIdx = IdxW'(NUM_SLOTS - 1);
  localparam logic [CntW-1:0] CntEnd  = CntW'(NUM_SLOTS);

  // slot tables
  logic [15:0]          key_mem   [NUM_SLOTS];
  logic [31:0]          stamp_mem [NUM_SLOTS];
  logic [NUM_SLOTS-1:0] valid_q;

  frag_t           frag_q;
  logic [CntW-1:0] cnt_q;
  logic            cmp_vld_q;
  logic [IdxW-1:0] cmp_idx_q;
  logic [15:0]     rd_key_q;
  logic [31:0]     rd_stamp_q;

  logic            have_match_q, have_free_q, have_old_q;
  logic [IdxW-1:0] match_idx_q, free_idx_q, old_idx_q;
  logic [31:0]     old_stamp_q;

  result_t         res_q;

  logic            issue;
  logic            step;
  logic [IdxW-1:0] pick;
  slot_status_e    status;
  logic [IdxW+3:0] pick_ext;
  logic [15:0]     boff;

  assign issue = cmd_i.scan && (cnt_q < CntEnd);
  assign step  = cmd_i.scan && cmp_vld_q;
  assign scan_done_o = step && (cmp_idx_q == LastIdx);

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) frag_q <= frag_i;
    if (issue) begin
      rd_key_q   <= key_mem[cnt_q[IdxW-1:0]];
      rd_stamp_q <= stamp_mem[cnt_q[IdxW-1:0]];
    end
    if (cmd_i.commit && (status != StatMatch)) begin
      key_mem[pick]   <= frag_q.frag_id;
      stamp_mem[pick] <= frag_q.now;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q      <= '0;
      cnt_q        <= '0;
      cmp_vld_q    <= 1'b0;
      cmp_idx_q    <= '0;
      have_match_q <= 1'b0;
      have_free_q  <= 1'b0;
      have_old_q   <= 1'b0;
      match_idx_q  <= '0;
      free_idx_q   <= '0;
      old_idx_q    <= '0;
      old_stamp_q  <= '0;
    end else begin
      cmp_vld_q <= issue;
      if (issue) begin
        cmp_idx_q <= cnt_q[IdxW-1:0];
        cnt_q     <= cnt_q + CntW'(1);
      end
      if (cmd_i.load) begin
        cnt_q        <= '0;
        cmp_vld_q    <= 1'b0;
        have_match_q <= 1'b0;
        have_free_q  <= 1'b0;
        have_old_q   <= 1'b0;
      end else if (step) begin
        if (!valid_q[cmp_idx_q]) begin
          have_free_q <= 1'b1;
          free_idx_q  <= cmp_idx_q;
        end else begin
          if (!have_match_q && (rd_key_q == frag_q.frag_id)) begin
            have_match_q <= 1'b1;
            match_idx_q  <= cmp_idx_q;
          end
          if (!have_old_q || (rd_stamp_q < old_stamp_q)) begin
            have_old_q  <= 1'b1;
            old_idx_q   <= cmp_idx_q;
            old_stamp_q <= rd_stamp_q;
          end
        end
      end
      // last fragment frees the slot, otherwise it stays taken
      if (cmd_i.commit) valid_q[pick] <= frag_q.more_fragments;
    end
  end

  always_comb begin
    if (have_match_q) begin
      pick   = match_idx_q;
      status = StatMatch;
    end else if (have_free_q) begin
      pick   = free_idx_q;
      status = StatFree;
    end else begin
      pick   = old_idx_q;
      status = StatEvict;
    end
    pick_ext = {4'b0000, pick};
    boff     = {frag_q.frag_offset, 3'b000};
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      res_q.slot        <= pick_ext[3:0];
      res_q.slot_status <= status;
      res_q.byte_offset <= boff;
      res_q.complete    <= !frag_q.more_fragments;
      res_q.total_len   <= frag_q.more_fragments ? 17'd0
                           : ({1'b0, boff} + {1'b0, frag_q.payload_len});
    end
  end

  assign result_o = res_q;

endmodule

FILE: rtl/ip_fragment_reassembly_slots.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ip_fragment_reassembly_slots
// IPv4 fragment reassembly slot table: match, free-slot or oldest eviction.
// ----------------------------------------------------------------------------
// Channel   Direction  Handshake                    Payload
// fragment  in         start, busy (accept: start & !busy)  frag_i
// result    out        result_valid_o (1-cycle strobe)     result_o
//
// From accept to result strobe, one slot is read from the key/stamp tables
// per cycle through a single read port; the read data is registered before
// the compare, and a commit state follows the last slot.
// busy drops in the cycle the result is strobed; a new item may be accepted
// in that same cycle. Reset marks every slot free; no clearing pass.
// The result cannot be stalled by the receiver.
// ----------------------------------------------------------------------------
module ip_fragment_reassembly_slots #(
  parameter int unsigned NUM_SLOTS = ipfr_pkg::NUM_SLOTS_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  ipfr_pkg::frag_t   frag_i,
  output logic              result_valid_o,
  output ipfr_pkg::result_t result_o
);
  import ipfr_pkg::*;

  ctrl_cmd_t cmd;
  logic      scan_done;

  ipfr_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start),
    .scan_done_i (scan_done),
    .cmd_o       (cmd),
    .busy_o      (busy),
    .done_o      (result_valid_o)
  );

  ipfr_dpath #(
    .NUM_SLOTS (NUM_SLOTS)
  ) u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .frag_i      (frag_i),
    .scan_done_o (scan_done),
    .result_o    (result_o)
  );

endmodule

FILE: rtl/ipfr_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ipfr_checker
// Port-level checks for the reassembly slot table, bound to the top level.
// ----------------------------------------------------------------------------
module ipfr_checker (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              start,
  input logic              busy,
  input logic              result_valid_o,
  input ipfr_pkg::result_t result_o
);
  import ipfr_pkg::*;

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy)
    else $error("accepted item did not raise busy");

  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> !busy)
    else $error("result strobed while busy");

  a_busy_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(busy) |-> result_valid_o)
    else $error("busy dropped without a result");

  a_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |=> !result_valid_o)
    else $error("back-to-back result strobes");

  a_total: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && !result_o.complete) |-> (result_o.total_len == 17'd0))
    else $error("total length set on a non-final fragment");

endmodule

bind ip_fragment_reassembly_slots ipfr_checker u_ipfr_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .start          (start),
  .busy           (busy),
  .result_valid_o (result_valid_o),
  .result_o       (result_o)
);

FILE: sim/ip_fragment_reassembly_slots_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ip_fragment_reassembly_slots_tb
// Self-checking bench for the IPv4 fragment reassembly slot table.
// A queue of fragments feeds a start/busy driver with random gaps. Each
// accepted item runs through a local slot table model that picks the match,
// free or eviction slot. The expected result is compared against the
// one-cycle result strobe. Directed items cover field extremes, fills,
// evictions and stamp ties. Random datagram sequences follow, mixed with noise.
// ----------------------------------------------------------------------------
module ip_fragment_reassembly_slots_tb;
  import ipfr_pkg::*;

  localparam int unsigned NSLOT      = NUM_SLOTS_DEF;
  localparam int unsigned IDLE_LIMIT = 1000;
  localparam int unsigned N_RANDOM   = 2000;

  typedef struct {
    frag_t       frag;
    int unsigned gap;
    bit          drain;
  } send_item_t;

  logic    clk_i  = 1'b0;
  logic    rst_ni = 1'b0;
  logic    start  = 1'b0;
  frag_t   frag_i = '0;
  logic    busy;
  logic    result_valid_o;
  result_t result_o;

  send_item_t  send_q[$];
  result_t     slot_results_q[$];
  logic        took = 1'b0;
  int unsigned err_cnt = 0;
  int unsigned idle_cycles = 0;
  int unsigned n_sent = 0, n_checked = 0;
  int unsigned n_match = 0, n_fresh = 0, n_evict = 0, n_done = 0;

  // slot table model
  bit          tbl_valid[NSLOT];
  logic [15:0] tbl_key[NSLOT];
  logic [31:0] tbl_stamp[NSLOT];

  ip_fragment_reassembly_slots u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .frag_i         (frag_i),
    .result_valid_o (result_valid_o),
    .result_o       (result_o)
  );

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    for (int i = 0; i < NSLOT; i++) tbl_valid[i] = 1'b0;
    rst_ni = 1'b0;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
  end

  function automatic result_t place_fragment(frag_t f);
    result_t     r;
    bit          have_match, have_free, have_old;
    int unsigned match_idx, free_idx, old_idx, pick;
    logic [31:0] old_stamp;
    have_match = 1'b0;
    have_free  = 1'b0;
    have_old   = 1'b0;
    match_idx  = 0;
    free_idx   = 0;
    old_idx    = 0;
    old_stamp  = '0;
    r          = '0;
    for (int i = 0; i < NSLOT; i++) begin
      if (!tbl_valid[i]) begin
        free_idx  = i;
        have_free = 1'b1;
      end else begin
        if (!have_match && tbl_key[i] == f.frag_id) begin
          match_idx  = i;
          have_match = 1'b1;
        end
        if (!have_old || tbl_stamp[i] < old_stamp) begin
          old_stamp = tbl_stamp[i];
          old_idx   = i;
          have_old  = 1'b1;
        end
      end
    end
    if (have_match) begin
      pick          = match_idx;
      r.slot_status = StatMatch;
    end else begin
      if (have_free) begin
        pick          = free_idx;
        r.slot_status = StatFree;
      end else begin
        pick          = old_idx;
        r.slot_status = StatEvict;
      end
      tbl_valid[pick] = 1'b1;
      tbl_key[pick]   = f.frag_id;
      tbl_stamp[pick] = f.now;
    end
    r.slot        = pick[3:0];
    r.byte_offset = {f.frag_offset, 3'b000};
    if (!f.more_fragments) begin
      r.complete      = 1'b1;
      r.total_len     = {1'b0, r.byte_offset} + {1'b0, f.payload_len};
      tbl_valid[pick] = 1'b0;
    end
    return r;
  endfunction

  task automatic check_field(string name, int unsigned exp_v, int unsigned act_v);
    if (exp_v != act_v) begin
      $error("%s mismatch: expected %0d, got %0d", name, exp_v, act_v);
      err_cnt++;
    end
  endtask

  task automatic queue_frag(logic [15:0] id, logic [12:0] offs, logic mf,
                            logic [15:0] plen, logic [31:0] stamp,
                            int unsigned gap, bit drain);
    send_item_t s;
    s.frag.frag_id        = id;
    s.frag.frag_offset    = offs;
    s.frag.more_fragments = mf;
    s.frag.payload_len    = plen;
    s.frag.now            = stamp;
    s.gap                 = gap;
    s.drain               = drain;
    send_q.push_back(s);
  endtask

  // driver
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      start <= 1'b0;
    end else if (!(start && !took)) begin
      if (send_q.size() == 0) begin
        start <= 1'b0;
      end else if (send_q[0].gap != 0) begin
        send_q[0].gap = send_q[0].gap - 1;
        start <= 1'b0;
      end else if (send_q[0].drain && (slot_results_q.size() != 0 || busy)) begin
        start <= 1'b0;
      end else begin
        frag_i <= send_q[0].frag;
        start  <= 1'b1;
        send_q.pop_front();
        n_sent++;
      end
    end
  end

  // monitor and checker
  always @(posedge clk_i) begin
    result_t exp_r;
    took <= rst_ni && start && !busy;
    if (rst_ni) begin
      if (result_valid_o) begin
        if (slot_results_q.size() == 0) begin
          $error("result with no item outstanding: slot %0d", result_o.slot);
          err_cnt++;
        end else begin
          exp_r = slot_results_q.pop_front();
          check_field("slot", 32'(exp_r.slot), 32'(result_o.slot));
          check_field("slot_status", 32'(exp_r.slot_status), 32'(result_o.slot_status));
          check_field("byte_offset", 32'(exp_r.byte_offset), 32'(result_o.byte_offset));
          check_field("complete", 32'(exp_r.complete), 32'(result_o.complete));
          check_field("total_len", 32'(exp_r.total_len), 32'(result_o.total_len));
          n_checked++;
        end
      end
      if (start && !busy) begin
        exp_r = place_fragment(frag_i);
        case (exp_r.slot_status)
          StatMatch: n_match++;
          StatFree:  n_fresh++;
          default:   n_evict++;
        endcase
        if (exp_r.complete) n_done++;
        slot_results_q.push_back(exp_r);
      end
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((start && !busy) || result_valid_o) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
        $display("watchdog: no progress for %0d cycles", IDLE_LIMIT);
        $display("FAILURE");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  // stimulus
  initial begin
    logic [15:0] open_ids[$];
    logic [31:0] clock_s;
    logic [15:0] id;
    int unsigned pick, roll, gap;
    bit          calm;

    // extremes, completion with oversize payload, unfragmented datagram
    queue_frag(16'h0000, 13'h0000, 1'b1, 16'h0000, 32'h0000_0000, 0, 1'b0);
    queue_frag(16'hFFFF, 13'h1FFF, 1'b1, 16'hFFFF, 32'hFFFF_FFFF, 3, 1'b0);
    queue_frag(16'hFFFF, 13'h1FFF, 1'b0, 16'hFFFF, 32'h0000_0000, 0, 1'b0);
    queue_frag(16'h1234, 13'h0000, 1'b0, 16'd1480, 32'd3, 10, 1'b0);
    // fill the remaining slots, all with the same stamp
    for (int k = 0; k < NSLOT - 1; k++)
      queue_frag(16'(16'h0100 + k), 13'h0000, 1'b1, 16'd1480, 32'd7,
                 $urandom_range(0, 10), 1'b0);
    // table full: evict the oldest, then break a stamp tie at the lowest index
    queue_frag(16'hABCD, 13'h00B9, 1'b1, 16'd1480, 32'd9, 0, 1'b0);
    queue_frag(16'hBEEF, 13'h0000, 1'b1, 16'd8, 32'd9, 1, 1'b0);
    queue_frag(16'h0105, 13'h0172, 1'b0, 16'd100, 32'd20, 0, 1'b0);
    queue_frag(16'h5555, 13'h0AAA, 1'b1, 16'h5555, 32'h5555_5555, 2, 1'b0);
    queue_frag(16'hABCD, 13'h1555, 1'b1, 16'hAAAA, 32'hAAAA_AAAA, 0, 1'b0);

    clock_s = 32'd100;
    calm    = 1'b0;
    for (int n = 0; n < N_RANDOM; n++) begin
      if (n % 100 == 0) calm = ($urandom_range(0, 2) == 0);
      gap = calm ? 0 : $urandom_range(0, 10);
      if ($urandom_range(0, 19) == 0) clock_s = $urandom();
      else clock_s = clock_s + $urandom_range(0, 3);
      roll = $urandom_range(0, 99);
      if (roll < 8) begin
        queue_frag(16'($urandom()), 13'($urandom()), 1'($urandom_range(0, 1)),
                   16'($urandom()), $urandom(), gap, n % 300 == 0);
      end else if (open_ids.size() == 0 || (roll < 35 && open_ids.size() < 22)) begin
        id = 16'($urandom());
        if ($urandom_range(0, 9) == 0) begin
          queue_frag(id, 13'h0000, 1'b0, 16'($urandom()), clock_s, gap, n % 300 == 0);
        end else begin
          open_ids.push_back(id);
          queue_frag(id, 13'h0000, 1'b1, 16'($urandom()), clock_s, gap, n % 300 == 0);
        end
      end else begin
        pick = $urandom_range(0, open_ids.size() - 1);
        id   = open_ids[pick];
        if ($urandom_range(0, 3) == 0) begin
          open_ids.delete(pick);
          queue_frag(id, 13'($urandom()), 1'b0, 16'($urandom()), clock_s, gap,
                     n % 300 == 0);
        end else begin
          queue_frag(id, 13'($urandom()), 1'b1, 16'($urandom()), clock_s, gap,
                     n % 300 == 0);
        end
      end
    end

    @(posedge rst_ni);
    while (send_q.size() != 0 || start) @(posedge clk_i);
    while (slot_results_q.size() != 0) @(posedge clk_i);
    repeat (2 * NSLOT + 8) @(posedge clk_i);

    $display("%0d fragments sent, %0d results checked", n_sent, n_checked);
    $display("slot picks: %0d matched, %0d free taken, %0d evicted; %0d datagrams completed",
             n_match, n_fresh, n_evict, n_done);
    if (err_cnt == 0 && slot_results_q.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
